// ----- design/nws_pkg.sv -----
// package: sizes, payload structs and control types for the nearest waypoint search
`default_nettype none

package nws_pkg;

    // table and coordinate sizing
    localparam int MAX_WAYPOINTS = 1024;
    localparam int COORD_BITS    = 24;
    localparam int ADDR_BITS     = $clog2(MAX_WAYPOINTS);
    localparam int CNT_BITS      = ADDR_BITS + 1;

    // fixed field widths of the request and response
    localparam int POS_BITS = 24;
    localparam int S_BITS   = 23;
    localparam int D_BITS   = 24;
    localparam int IDX_BITS = 10;

    // distance datapath widths
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * COORD_BITS + 1;
    localparam int SUM_BITS  = SQ_BITS + 1;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        op_t                         op;
        logic                        set_start;
        logic signed [POS_BITS-1:0]  pos_x;
        logic signed [POS_BITS-1:0]  pos_y;
        logic        [S_BITS-1:0]    arc_s;
        logic signed [D_BITS-1:0]    lateral_d;
    } req_t;

    typedef struct packed {
        logic        [IDX_BITS-1:0]  nearest_index;
        logic        [S_BITS-1:0]    near_s;
        logic signed [D_BITS-1:0]    near_d;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH
    } state_t;

    // stored position of one waypoint
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } xy_word_t;

    // stored path coordinates of one waypoint
    typedef struct packed {
        logic        [S_BITS-1:0] s;
        logic signed [D_BITS-1:0] d;
    } sd_word_t;

    // tag that travels with each scanned entry
    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic [ADDR_BITS-1:0] idx;
    } scan_tag_t;

    // scan outcome back to the controller
    typedef struct packed {
        logic                 done;
        logic [ADDR_BITS-1:0] best_idx;
    } scan_res_t;

endpackage

`default_nettype wire

// ----- design/nearest_waypoint_search.sv -----
// top level: waypoint table memories, scan control and response register
`default_nettype none

// A load request (op 0) appends a waypoint; set_start empties the table first, and
// loads into a full table are dropped. A query request (op 1) scans the stored
// waypoints one per cycle through the single read port of the position memory, then
// drains the read and distance pipeline, fetches s and d of the winner, and returns
// the closest entry, earliest on ties. A query on an empty table gives no response.
// Requests are taken only while no query is running; a finished response waits in its
// own register, so loads may still be taken while it is pending.

module nearest_waypoint_search
    import nws_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    xy_word_t xy_mem [MAX_WAYPOINTS];
    sd_word_t sd_mem [MAX_WAYPOINTS];

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_BITS-1:0]      count_reg;
    logic [CNT_BITS-1:0]      count_next;
    logic [ADDR_BITS-1:0]     rd_addr_reg;
    logic [ADDR_BITS-1:0]     rd_addr_next;
    logic signed [COORD_BITS-1:0] qx_reg;
    logic signed [COORD_BITS-1:0] qy_reg;
    logic [ADDR_BITS-1:0]     best_idx_reg;
    xy_word_t                 xy_rd_reg;
    sd_word_t                 sd_rd_reg;
    scan_tag_t                tag_reg;
    scan_tag_t                tag_next;
    scan_res_t                res;
    logic                     rsp_valid_reg;
    rsp_t                     rsp_reg;

    logic                     accept;
    logic                     is_load;
    logic                     is_query;
    logic                     room;
    logic                     wr_en;
    logic [ADDR_BITS-1:0]     wr_addr;
    xy_word_t                 wr_xy;
    sd_word_t                 wr_sd;
    logic                     scan_last;
    logic                     xy_rd_en;
    logic                     sd_rd_en;
    logic                     rsp_load;
    logic [POS_BITS+COORD_BITS-1:0] wide_x;
    logic [POS_BITS+COORD_BITS-1:0] wide_y;
    logic [ADDR_BITS+IDX_BITS-1:0]  idx_wide;

    // request decode
    assign accept   = req_valid && req_ready;
    assign is_load  = accept && (req.op == OP_LOAD);
    assign is_query = accept && (req.op == OP_QUERY) && (count_reg != '0);
    assign room     = count_reg < CNT_BITS'(MAX_WAYPOINTS);
    assign wr_en    = is_load && (req.set_start || room);
    assign wr_addr  = req.set_start ? '0 : count_reg[ADDR_BITS-1:0];

    // coordinates copied at the stored width (request and stored widths are equal)
    assign wide_x   = {{COORD_BITS{1'b0}}, req.pos_x};
    assign wide_y   = {{COORD_BITS{1'b0}}, req.pos_y};
    assign wr_xy.x  = wide_x[COORD_BITS-1:0];
    assign wr_xy.y  = wide_y[COORD_BITS-1:0];
    assign wr_sd.s  = req.arc_s;
    assign wr_sd.d  = req.lateral_d;

    assign scan_last = {1'b0, rd_addr_reg} == (count_reg - 1'b1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (is_query)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (res.done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb
    begin
        req_ready = 1'b0;
        xy_rd_en  = 1'b0;
        sd_rd_en  = 1'b0;
        rsp_load  = 1'b0;
        tag_next  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_SCAN:
            begin
                xy_rd_en       = 1'b1;
                tag_next.valid = 1'b1;
                tag_next.first = rd_addr_reg == '0;
                tag_next.last  = scan_last;
                tag_next.idx   = rd_addr_reg;
            end
            ST_DRAIN:
            begin
                sd_rd_en = res.done;
            end
            ST_FETCH:
            begin
                rsp_load = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // count and scan address
    always_comb
    begin
        count_next = count_reg;
        if (wr_en)
        begin
            count_next = req.set_start ? CNT_BITS'(1) : count_reg + 1'b1;
        end
        rd_addr_next = rd_addr_reg;
        if (is_query)
        begin
            rd_addr_next = '0;
        end
        else if (xy_rd_en)
        begin
            rd_addr_next = rd_addr_reg + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_addr_reg   <= '0;
            tag_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_addr_reg <= rd_addr_next;
            tag_reg     <= tag_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // query position and winner index
    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            qx_reg <= wr_xy.x;
            qy_reg <= wr_xy.y;
        end
        if (sd_rd_en)
        begin
            best_idx_reg <= res.best_idx;
        end
    end

    // position memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            xy_mem[wr_addr] <= wr_xy;
        end
        if (xy_rd_en)
        begin
            xy_rd_reg <= xy_mem[rd_addr_reg];
        end
    end

    // path coordinate memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sd_mem[wr_addr] <= wr_sd;
        end
        if (sd_rd_en)
        begin
            sd_rd_reg <= sd_mem[res.best_idx];
        end
    end

    nws_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .tag   (tag_reg),
        .xy    (xy_rd_reg),
        .qx    (qx_reg),
        .qy    (qy_reg),
        .res   (res)
    );

    // response register
    assign idx_wide = {{IDX_BITS{1'b0}}, best_idx_reg};

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg.nearest_index <= idx_wide[IDX_BITS-1:0];
            rsp_reg.near_s        <= sd_rd_reg.s;
            rsp_reg.near_d        <= sd_rd_reg.d;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- design/nws_dist.sv -----
// distance pipeline and running minimum over one scan
`default_nettype none

module nws_dist
    import nws_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire scan_tag_t                     tag,
    input  wire xy_word_t                      xy,
    input  wire logic signed [COORD_BITS-1:0]  qx,
    input  wire logic signed [COORD_BITS-1:0]  qy,
    output scan_res_t                          res
);

    logic [DIFF_BITS-1:0]   diff_x;
    logic [DIFF_BITS-1:0]   diff_y;
    logic [DIFF_BITS-1:0]   mag_x;
    logic [DIFF_BITS-1:0]   mag_y;
    logic [DIFF_BITS-1:0]   mag_x_reg;
    logic [DIFF_BITS-1:0]   mag_y_reg;
    logic [2*DIFF_BITS-1:0] prod_x;
    logic [2*DIFF_BITS-1:0] prod_y;
    logic [SQ_BITS-1:0]     sq_x_reg;
    logic [SQ_BITS-1:0]     sq_y_reg;
    logic [SUM_BITS-1:0]    sum;
    logic [SUM_BITS-1:0]    best_dist_reg;
    logic [ADDR_BITS-1:0]   best_idx_reg;
    logic                   done_reg;
    logic                   update;
    scan_tag_t              tag_a_reg;
    scan_tag_t              tag_b_reg;

    // exact differences and their magnitudes
    always_comb
    begin
        diff_x = {xy.x[COORD_BITS-1], xy.x} - {qx[COORD_BITS-1], qx};
        diff_y = {xy.y[COORD_BITS-1], xy.y} - {qy[COORD_BITS-1], qy};
        mag_x  = diff_x[DIFF_BITS-1] ? (~diff_x + 1'b1) : diff_x;
        mag_y  = diff_y[DIFF_BITS-1] ? (~diff_y + 1'b1) : diff_y;
    end

    // squares of the magnitudes
    assign prod_x = mag_x_reg * mag_x_reg;
    assign prod_y = mag_y_reg * mag_y_reg;

    // squared distance and strict compare keeps the earliest on ties
    assign sum    = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign update = tag_b_reg.valid && (tag_b_reg.first || (sum < best_dist_reg));

    // tag pipeline and done flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            tag_a_reg <= tag;
            tag_b_reg <= tag_a_reg;
            done_reg  <= tag_b_reg.valid && tag_b_reg.last;
        end
    end

    // datapath stages and running best
    always_ff @(posedge clk)
    begin
        mag_x_reg <= mag_x;
        mag_y_reg <= mag_y;
        sq_x_reg  <= prod_x[SQ_BITS-1:0];
        sq_y_reg  <= prod_y[SQ_BITS-1:0];
        if (update)
        begin
            best_dist_reg <= sum;
            best_idx_reg  <= tag_b_reg.idx;
        end
    end

    assign res.done     = done_reg;
    assign res.best_idx = best_idx_reg;

endmodule

`default_nettype wire
